/* sv/bpd_pkg.sv */
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types and constants of the bootloader packet deframer.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] KIND_STATUS  = 3'd0;
    localparam logic [2:0] KIND_VERSION = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_WRITE   = 3'd3;
    localparam logic [2:0] KIND_HANDOFF = 3'd4;

    localparam logic [7:0] ST_OK      = 8'h00;
    localparam logic [7:0] ST_ERROR   = 8'h01;
    localparam logic [7:0] ST_INVALID = 8'h02;

    localparam logic [7:0] CMD_UNLOCK  = 8'hA0;
    localparam logic [7:0] CMD_DATA    = 8'hA1;
    localparam logic [7:0] CMD_VERIFY  = 8'hA2;
    localparam logic [7:0] CMD_RESET   = 8'hA3;
    localparam logic [7:0] CMD_VERSION = 8'hA4;

    localparam logic [2:0] REG_HOST_ID = 3'd0;
    localparam logic [2:0] REG_GAP     = 3'd1;
    localparam logic [2:0] REG_RSTART  = 3'd2;
    localparam logic [2:0] REG_RLEN    = 3'd3;
    localparam logic [2:0] REG_VERSION = 3'd4;

    localparam logic [31:0] GUARD_WORD = 32'h5048434D;

    // Work handed from the parser to the command engine.
    typedef enum logic [1:0] {
        JOB_PAYLOAD = 2'd0,
        JOB_CMD     = 2'd1,
        JOB_BOTH    = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;
        logic [31:0] pos;
        logic [7:0]  cmd;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [31:0] size;
    } job_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  code;
        logic [31:0] address;
        logic [31:0] count;
        logic        last;
    } result_t;

endpackage

/* sv/bootloader_packet_deframer_unit.sv */
// ----------------------------------------------------------------------------
// bootloader_packet_deframer_unit
// CAN bootloader packet deframer: parser front end, command back end.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | mode, frame_id, data_byte
// m_axis   | out       | kind, code, address, count, last
// cfg      | in        | write of host_id, gap, region, version registers
//
// The parser takes one item a cycle while its job register is free or being taken;
// a result passes the job register and the engine queue. The engine drains one
// result a cycle while m_axis is ready and holds a job until one result is left.
// Reset clears all parsing state, unlock bounds and queued results at once.
module bootloader_packet_deframer_unit #(
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // mode[1:0], frame_id[30:2], data_byte[38:31]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // code[7:0], address[39:8], count[71:40]
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [28:0] host_id_reg;
    logic [15:0] gap_reg, version_reg;
    logic [31:0] rstart_reg, rlen_reg;
    logic              job_valid, job_ready;
    bpd_pkg::job_t     job;
    bpd_pkg::result_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_id_reg <= '0;
            gap_reg     <= 16'd100;
            rstart_reg  <= 32'h0011_0000;
            rlen_reg    <= 32'h0010_0000;
            version_reg <= 16'h0100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpd_pkg::REG_HOST_ID: host_id_reg <= cfg_data[28:0];
                bpd_pkg::REG_GAP:     gap_reg     <= cfg_data[15:0];
                bpd_pkg::REG_RSTART:  rstart_reg  <= cfg_data;
                bpd_pkg::REG_RLEN:    rlen_reg    <= cfg_data;
                bpd_pkg::REG_VERSION: version_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    bpd_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .mode              (s_axis_tdata[1:0]),
        .frame_id          (s_axis_tdata[30:2]),
        .data_byte         (s_axis_tdata[38:31]),
        .host_id           (host_id_reg),
        .gap_timeout_ticks (gap_reg),
        .job_valid         (job_valid),
        .job_ready         (job_ready),
        .job               (job)
    );

    bpd_engine #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job),
        .region_start  (rstart_reg),
        .region_length (rlen_reg),
        .version_word  (version_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .result        (res)
    );

    assign m_axis_tdata = {res.count, res.address, res.code};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

/* sv/bpd_parser.sv */
// ----------------------------------------------------------------------------
// bpd_parser
// Front part: frame filtering, gap timing, guard and header parsing.
// ----------------------------------------------------------------------------
module bpd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [28:0]       frame_id,
    input  logic [7:0]        data_byte,
    input  logic [28:0]       host_id,
    input  logic [15:0]       gap_timeout_ticks,
    output logic              job_valid,
    input  logic              job_ready,
    output bpd_pkg::job_t     job
);

    logic        in_payload_reg, frame_skipped_reg, frame_seen_reg;
    logic [31:0] byte_pos_reg, packet_size_reg, first_word_reg, second_word_reg;
    logic [7:0]  command_code_reg;
    logic [15:0] idle_ticks_reg;
    logic        job_valid_reg;
    bpd_pkg::job_t job_reg;

    logic        in_payload_next, frame_skipped_next, frame_seen_next;
    logic [31:0] byte_pos_next, packet_size_next, first_word_next, second_word_next;
    logic [7:0]  command_code_next;
    logic [15:0] idle_ticks_next;
    logic        emit;
    bpd_pkg::job_t job_next;
    logic        take;
    logic [31:0] pos_inc;
    logic [7:0]  guard_byte;

    function automatic logic [7:0] GUARD_BYTE_SEL(input logic [1:0] i);
        logic [31:0] g;
        g = bpd_pkg::GUARD_WORD >> {i, 3'b000};
        return g[7:0];
    endfunction

    assign in_ready  = !job_valid_reg || job_ready;
    assign take      = in_valid && in_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    assign pos_inc   = byte_pos_reg + 32'd1;

    always_comb
    begin
        guard_byte = GUARD_BYTE_SEL(byte_pos_reg[1:0]);
    end

    always_comb
    begin
        in_payload_next    = in_payload_reg;
        frame_skipped_next = frame_skipped_reg;
        frame_seen_next    = frame_seen_reg;
        byte_pos_next      = byte_pos_reg;
        packet_size_next   = packet_size_reg;
        first_word_next    = first_word_reg;
        second_word_next   = second_word_reg;
        command_code_next  = command_code_reg;
        idle_ticks_next    = idle_ticks_reg;
        emit               = 1'b0;
        job_next           = job_reg;
        if (take)
        begin
            case (mode)
                bpd_pkg::MODE_FRAME:
                begin
                    if (frame_id != host_id)
                        frame_skipped_next = 1'b1;
                    else
                    begin
                        frame_skipped_next = 1'b0;
                        if (frame_seen_reg && idle_ticks_reg > gap_timeout_ticks)
                        begin
                            in_payload_next = 1'b0;
                            byte_pos_next   = '0;
                        end
                        frame_seen_next = 1'b1;
                        idle_ticks_next = '0;
                    end
                end
                bpd_pkg::MODE_BYTE:
                begin
                    if (!frame_skipped_reg)
                    begin
                        idle_ticks_next = '0;
                        if (!in_payload_reg)
                        begin
                            byte_pos_next = pos_inc;
                            if (byte_pos_reg < 32'd4)
                            begin
                                if (data_byte != guard_byte)
                                    byte_pos_next = '0;
                            end
                            else if (byte_pos_reg < 32'd8)
                            begin
                                case (byte_pos_reg[1:0])
                                    2'd0: packet_size_next = {24'd0, data_byte};
                                    2'd1: packet_size_next[15:8]  = data_byte;
                                    2'd2: packet_size_next[23:16] = data_byte;
                                    default: packet_size_next[31:24] = data_byte;
                                endcase
                            end
                            else
                            begin
                                command_code_next = data_byte;
                                in_payload_next   = 1'b1;
                                byte_pos_next     = '0;
                                if (packet_size_reg == 32'd0)
                                begin
                                    emit            = 1'b1;
                                    in_payload_next = 1'b0;
                                    job_next.kind   = bpd_pkg::JOB_CMD;
                                    job_next.cmd    = data_byte;
                                end
                            end
                        end
                        else
                        begin
                            if (byte_pos_reg < 32'd4)
                            begin
                                case (byte_pos_reg[1:0])
                                    2'd0: first_word_next[7:0]   = data_byte;
                                    2'd1: first_word_next[15:8]  = data_byte;
                                    2'd2: first_word_next[23:16] = data_byte;
                                    default: first_word_next[31:24] = data_byte;
                                endcase
                            end
                            else if (byte_pos_reg < 32'd8)
                            begin
                                case (byte_pos_reg[1:0])
                                    2'd0: second_word_next[7:0]   = data_byte;
                                    2'd1: second_word_next[15:8]  = data_byte;
                                    2'd2: second_word_next[23:16] = data_byte;
                                    default: second_word_next[31:24] = data_byte;
                                endcase
                            end
                            emit          = 1'b1;
                            byte_pos_next = pos_inc;
                            job_next.kind = bpd_pkg::JOB_PAYLOAD;
                            job_next.cmd  = command_code_reg;
                            if (pos_inc == packet_size_reg)
                            begin
                                job_next.kind   = bpd_pkg::JOB_BOTH;
                                in_payload_next = 1'b0;
                                byte_pos_next   = '0;
                            end
                        end
                        job_next.data        = data_byte;
                        job_next.pos         = byte_pos_reg;
                        job_next.first_word  = first_word_next;
                        job_next.second_word = second_word_next;
                        job_next.size        = packet_size_reg;
                    end
                end
                bpd_pkg::MODE_TICK:
                begin
                    if (idle_ticks_reg != 16'hFFFF)
                        idle_ticks_next = idle_ticks_reg + 16'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg    <= 1'b0;
            frame_skipped_reg <= 1'b0;
            frame_seen_reg    <= 1'b0;
            byte_pos_reg      <= '0;
            packet_size_reg   <= '0;
            first_word_reg    <= '0;
            second_word_reg   <= '0;
            command_code_reg  <= '0;
            idle_ticks_reg    <= '0;
            job_valid_reg     <= 1'b0;
        end
        else
        begin
            in_payload_reg    <= in_payload_next;
            frame_skipped_reg <= frame_skipped_next;
            frame_seen_reg    <= frame_seen_next;
            byte_pos_reg      <= byte_pos_next;
            packet_size_reg   <= packet_size_next;
            first_word_reg    <= first_word_next;
            second_word_reg   <= second_word_next;
            command_code_reg  <= command_code_next;
            idle_ticks_reg    <= idle_ticks_next;
            if (take)
                job_valid_reg <= emit;
            else if (job_ready)
                job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
            job_reg <= job_next;
    end

endmodule

/* sv/bpd_engine.sv */
// ----------------------------------------------------------------------------
// bpd_engine
// Back part: turns parser jobs into result items, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module bpd_engine #(
    parameter int BLOCK_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  bpd_pkg::job_t     job,
    input  logic [31:0]       region_start,
    input  logic [31:0]       region_length,
    input  logic [15:0]       version_word,
    output logic              out_valid,
    input  logic              out_ready,
    output bpd_pkg::result_t  result
);

    localparam logic [31:0] ADDR_MASK = ~(32'(BLOCK_BYTES) - 32'd1);

    // Up to four results are queued; slot 0 is presented at the output.
    bpd_pkg::result_t seq_reg [4];
    logic [2:0]       cnt_reg;
    logic [31:0]      unlock_low_reg, unlock_high_reg;

    bpd_pkg::result_t seq_new [4];
    logic [2:0]       n_new;
    logic [31:0]      unlock_low_next, unlock_high_next;
    logic [32:0]      end_sum, limit_sum;
    logic [31:0]      addr;
    logic             load, pop;

    assign out_valid = cnt_reg != 3'd0;
    assign result    = seq_reg[0];
    assign pop       = out_valid && out_ready;
    assign job_ready = cnt_reg == 3'd0 || (cnt_reg == 3'd1 && out_ready);
    assign load      = job_valid && job_ready;
    assign end_sum   = {1'b0, job.first_word} + {1'b0, job.second_word};
    assign limit_sum = {1'b0, region_start} + {1'b0, region_length};
    assign addr      = job.first_word & ADDR_MASK;

    function automatic bpd_pkg::result_t mk(input logic [2:0] k, input logic [7:0] c,
                                            input logic [31:0] a, input logic [31:0] n);
        bpd_pkg::result_t r;
        r.kind = k; r.code = c; r.address = a; r.count = n; r.last = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        bpd_pkg::result_t cmd_res [3];
        logic [1:0] n_cmd;
        logic       base;
        unlock_low_next  = unlock_low_reg;
        unlock_high_next = unlock_high_reg;
        for (int i = 0; i < 3; i++)
            cmd_res[i] = mk(bpd_pkg::KIND_STATUS, bpd_pkg::ST_OK, '0, '0);
        n_cmd = 2'd1;
        case (job.cmd)
            bpd_pkg::CMD_UNLOCK:
            begin
                if (job.first_word == region_start && end_sum <= limit_sum && !end_sum[32])
                begin
                    unlock_low_next  = job.first_word;
                    unlock_high_next = end_sum[31:0];
                end
                else
                begin
                    unlock_low_next  = '0;
                    unlock_high_next = '0;
                    cmd_res[0] = mk(bpd_pkg::KIND_STATUS, bpd_pkg::ST_ERROR, '0, '0);
                end
            end
            bpd_pkg::CMD_DATA:
            begin
                if (unlock_low_reg <= addr && addr < unlock_high_reg)
                begin
                    cmd_res[0] = mk(bpd_pkg::KIND_WRITE, bpd_pkg::CMD_DATA, addr,
                                    (job.size >= 32'd4) ? job.size - 32'd4 : 32'd0);
                    n_cmd = 2'd2;
                end
                else
                    cmd_res[0] = mk(bpd_pkg::KIND_STATUS, bpd_pkg::ST_ERROR, '0, '0);
            end
            bpd_pkg::CMD_VERIFY:
                cmd_res[0] = mk(bpd_pkg::KIND_HANDOFF, bpd_pkg::CMD_VERIFY,
                                job.first_word, '0);
            bpd_pkg::CMD_RESET:
            begin
                cmd_res[1] = mk(bpd_pkg::KIND_HANDOFF, bpd_pkg::CMD_RESET,
                                job.first_word, '0);
                n_cmd = 2'd2;
            end
            bpd_pkg::CMD_VERSION:
            begin
                cmd_res[1] = mk(bpd_pkg::KIND_VERSION, version_word[15:8], '0, '0);
                cmd_res[2] = mk(bpd_pkg::KIND_VERSION, version_word[7:0], '0, '0);
                n_cmd = 2'd3;
            end
            default:
                cmd_res[0] = mk(bpd_pkg::KIND_STATUS, bpd_pkg::ST_INVALID, '0, '0);
        endcase
        base = job.kind != bpd_pkg::JOB_CMD;
        seq_new[0] = mk(bpd_pkg::KIND_PAYLOAD, job.data, '0, job.pos);
        for (int i = 1; i < 4; i++)
            seq_new[i] = cmd_res[i - 1];
        if (!base)
            for (int i = 0; i < 3; i++)
                seq_new[i] = cmd_res[i];
        if (job.kind == bpd_pkg::JOB_PAYLOAD)
        begin
            n_new = 3'd1;
            unlock_low_next  = unlock_low_reg;
            unlock_high_next = unlock_high_reg;
        end
        else
            n_new = {1'b0, n_cmd} + {2'b00, base};
        for (int i = 0; i < 4; i++)
            seq_new[i].last = (3'(i) + 3'd1 == n_new);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            unlock_low_reg  <= '0;
            unlock_high_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg         <= n_new;
            unlock_low_reg  <= unlock_low_next;
            unlock_high_reg <= unlock_high_next;
        end
        else if (pop)
            cnt_reg <= cnt_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            for (int i = 0; i < 4; i++)
                seq_reg[i] <= seq_new[i];
        else if (pop)
        begin
            for (int i = 0; i < 3; i++)
                seq_reg[i] <= seq_reg[i + 1];
        end
    end

endmodule
